// ----- design/ted_pkg.sv -----
// Shared types and constants of the terminal escape decoder.
package ted_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;

  typedef enum logic [3:0] {
    CMD_PUT_CHAR   = 4'd0,
    CMD_BELL       = 4'd1,
    CMD_MOVE       = 4'd2,
    CMD_CLEAR_EOS  = 4'd3,
    CMD_CLEAR_EOL  = 4'd4,
    CMD_INS_LINE   = 4'd5,
    CMD_DEL_LINE   = 4'd6,
    CMD_TEXT_COLOR = 4'd7,
    CMD_PALETTE    = 4'd8,
    CMD_TITLE_CHAR = 4'd9,
    CMD_TITLE_END  = 4'd10
  } cmd_t;

  typedef enum logic [4:0] {
    MODE_NORMAL = 5'd0,
    MODE_ESC    = 5'd1,
    MODE_COL9   = 5'd2,
    MODE_COL0   = 5'd4,
    MODE_YROW   = 5'd6,
    MODE_YCOL   = 5'd7,
    MODE_PALSEL = 5'd8,
    MODE_PALVAL = 5'd9,
    MODE_TSTART = 5'd10,
    MODE_TBODY  = 5'd11,
    MODE_KEY    = 5'd12,
    MODE_KDELIM = 5'd13,
    MODE_KBODY  = 5'd14,
    MODE_RKEY   = 5'd15,
    MODE_RDONE  = 5'd16
  } mode_t;

  localparam logic [1:0] SLOT_FG  = 2'd0;
  localparam logic [1:0] SLOT_BG  = 2'd1;
  localparam logic [1:0] SLOT_REV = 2'd2;

  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [7:0] SEQ_CLEAR_EOS = 8'h4A;
  localparam logic [7:0] SEQ_CLEAR_EOL = 8'h4B;
  localparam logic [7:0] SEQ_HOME_CLR  = 8'h76;
  localparam logic [7:0] SEQ_INS_LINE  = 8'h4C;
  localparam logic [7:0] SEQ_DEL_LINE  = 8'h4D;
  localparam logic [7:0] SEQ_HOME      = 8'h48;
  localparam logic [7:0] SEQ_REV_INDEX = 8'h49;
  localparam logic [7:0] SEQ_UP        = 8'h41;
  localparam logic [7:0] SEQ_DOWN      = 8'h42;
  localparam logic [7:0] SEQ_RIGHT     = 8'h43;
  localparam logic [7:0] SEQ_LEFT      = 8'h44;
  localparam logic [7:0] SEQ_COLOR9    = 8'h39;
  localparam logic [7:0] SEQ_COLOR0    = 8'h30;
  localparam logic [7:0] SEQ_ADDR      = 8'h59;
  localparam logic [7:0] SEQ_PALETTE   = 8'h37;
  localparam logic [7:0] SEQ_TITLE     = 8'h54;
  localparam logic [7:0] SEQ_KEY_BIND  = 8'h6B;
  localparam logic [7:0] SEQ_KEY_REP   = 8'h72;

  localparam logic [7:0] SEL_FG_LO  = 8'h66;
  localparam logic [7:0] SEL_FG_UP  = 8'h46;
  localparam logic [7:0] SEL_BG_LO  = 8'h62;
  localparam logic [7:0] SEL_BG_UP  = 8'h42;
  localparam logic [7:0] SEL_REV_LO = 8'h72;
  localparam logic [7:0] SEL_REV_UP = 8'h52;

  localparam logic [7:0] COLOR_NINE = 8'd2;
  localparam logic [7:0] COLOR_ZERO = 8'd0;

  typedef struct packed {
    cmd_t       cmd;
    logic [5:0] row;
    logic [6:0] col;
    logic [7:0] value;
    logic [1:0] slot;
    logic       scroll;
  } res_t;

endpackage

// ----- design/ted_cfg.sv -----
// Screen size registers, held as last valid row and column.
module ted_cfg #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ted_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ted_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [$clog2(MAX_COLS)-1:0]    cols_last,
  output logic [$clog2(MAX_ROWS)-1:0]    rows_last
);
  import ted_pkg::*;

  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int RST_COLS = (80 > MAX_COLS) ? MAX_COLS : 80;
  localparam int RST_ROWS = (40 > MAX_ROWS) ? MAX_ROWS : 40;

  logic [COL_W-1:0] cols_last_r, cols_last_nxt;
  logic [ROW_W-1:0] rows_last_r, rows_last_nxt;
  logic [7:0]       cols_in;
  logic [6:0]       rows_in;

  always_comb begin
    cols_in = cfg_data;
    rows_in = cfg_data[6:0];
    if (cols_in == 8'd0) begin
      cols_last_nxt = '0;
    end else if (9'(cols_in) > 9'(MAX_COLS)) begin
      cols_last_nxt = COL_W'(MAX_COLS - 1);
    end else begin
      cols_last_nxt = COL_W'(cols_in - 8'd1);
    end
    if (rows_in == 7'd0) begin
      rows_last_nxt = '0;
    end else if (9'(rows_in) > 9'(MAX_ROWS)) begin
      rows_last_nxt = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_last_nxt = ROW_W'(rows_in - 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_last_r <= COL_W'(RST_COLS - 1);
      rows_last_r <= ROW_W'(RST_ROWS - 1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMNS: cols_last_r <= cols_last_nxt;
        CFG_ROWS:    rows_last_r <= rows_last_nxt;
      endcase
    end
  end

  assign cols_last = cols_last_r;
  assign rows_last = rows_last_r;

endmodule

// ----- design/ted_parser.sv -----
// Escape state, cursor and single-pass byte decode.
module ted_parser #(
  parameter int MAX_COLS     = 128,
  parameter int MAX_ROWS     = 64,
  parameter int STRING_LIMIT = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [7:0]                  byte_in,
  input  logic [$clog2(MAX_COLS)-1:0] cols_last,
  input  logic [$clog2(MAX_ROWS)-1:0] rows_last,
  output logic                        emit,
  output ted_pkg::res_t               res
);
  import ted_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int CNT_W = $clog2(STRING_LIMIT + 1);

  mode_t            mode_r, mode_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [7:0]       fsb_r, fsb_nxt;
  logic [7:0]       delim_r, delim_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [ROW_W-1:0] r;
  logic [COL_W-1:0] c;
  logic             mv;
  logic [ROW_W:0]   mv_row;
  logic [COL_W:0]   mv_col;
  logic [COL_W:0]   tab_col;
  logic [7:0]       ycol_m;
  logic [7:0]       yrow_m;
  logic             str_end;

  always_comb begin
    r       = (row_r > rows_last) ? rows_last : row_r;
    c       = (col_r > cols_last) ? cols_last : col_r;
    tab_col = ({1'b0, c} | (COL_W + 1)'(7)) + (COL_W + 1)'(1);
    ycol_m  = byte_in - CH_SPACE;
    yrow_m  = fsb_r - CH_SPACE;
    str_end = (byte_in == delim_r) || (byte_in == CH_LF) ||
              (cnt_r >= CNT_W'(STRING_LIMIT));

    mode_nxt   = MODE_NORMAL;
    row_nxt    = r;
    col_nxt    = c;
    fsb_nxt    = fsb_r;
    delim_nxt  = delim_r;
    cnt_nxt    = cnt_r;
    emit       = 1'b0;
    mv         = 1'b0;
    mv_row     = '0;
    mv_col     = '0;
    res.cmd    = CMD_PUT_CHAR;
    res.row    = 6'(r);
    res.col    = 7'(c);
    res.value  = 8'd0;
    res.slot   = SLOT_FG;
    res.scroll = 1'b0;

    unique case (mode_r)
      MODE_NORMAL: begin
        if (byte_in >= CH_SPACE) begin
          emit      = 1'b1;
          res.value = byte_in;
          if (c == cols_last) begin
            col_nxt = '0;
            if (r == rows_last) begin
              res.scroll = 1'b1;
            end else begin
              row_nxt = r + ROW_W'(1);
            end
          end else begin
            col_nxt = c + COL_W'(1);
          end
        end else begin
          unique case (byte_in)
            CH_ESC: mode_nxt = MODE_ESC;
            CH_BS: begin
              if (c != '0) begin
                mv     = 1'b1;
                mv_row = {1'b0, r};
                mv_col = {1'b0, c - COL_W'(1)};
              end
            end
            CH_BEL: begin
              emit    = 1'b1;
              res.cmd = CMD_BELL;
            end
            CH_LF: begin
              mv     = 1'b1;
              mv_row = {1'b0, r} + (ROW_W + 1)'(1);
              mv_col = {1'b0, c};
            end
            CH_CR: begin
              mv     = 1'b1;
              mv_row = {1'b0, r};
            end
            CH_TAB: begin
              mv = 1'b1;
              if (tab_col > {1'b0, cols_last}) begin
                mv_row = {1'b0, r} + (ROW_W + 1)'(1);
              end else begin
                mv_row = {1'b0, r};
                mv_col = tab_col;
              end
            end
            default: ;
          endcase
        end
      end
      MODE_ESC: begin
        unique case (byte_in)
          SEQ_CLEAR_EOS: begin
            emit    = 1'b1;
            res.cmd = CMD_CLEAR_EOS;
          end
          SEQ_CLEAR_EOL: begin
            emit    = 1'b1;
            res.cmd = CMD_CLEAR_EOL;
          end
          SEQ_HOME_CLR: begin
            emit    = 1'b1;
            res.cmd = CMD_CLEAR_EOS;
            res.row = 6'd0;
            res.col = 7'd0;
            row_nxt = '0;
            col_nxt = '0;
          end
          SEQ_INS_LINE: begin
            emit    = 1'b1;
            res.cmd = CMD_INS_LINE;
          end
          SEQ_DEL_LINE: begin
            emit    = 1'b1;
            res.cmd = CMD_DEL_LINE;
          end
          SEQ_HOME: mv = 1'b1;
          SEQ_REV_INDEX: begin
            if (r == '0) begin
              emit    = 1'b1;
              res.cmd = CMD_INS_LINE;
            end else begin
              mv     = 1'b1;
              mv_row = {1'b0, r - ROW_W'(1)};
              mv_col = {1'b0, c};
            end
          end
          SEQ_UP: begin
            if (r != '0) begin
              mv     = 1'b1;
              mv_row = {1'b0, r - ROW_W'(1)};
              mv_col = {1'b0, c};
            end
          end
          SEQ_DOWN: begin
            if (r < rows_last) begin
              mv     = 1'b1;
              mv_row = {1'b0, r} + (ROW_W + 1)'(1);
              mv_col = {1'b0, c};
            end
          end
          SEQ_RIGHT: begin
            if (c < cols_last) begin
              mv     = 1'b1;
              mv_row = {1'b0, r};
              mv_col = {1'b0, c} + (COL_W + 1)'(1);
            end
          end
          SEQ_LEFT: begin
            if (c != '0) begin
              mv     = 1'b1;
              mv_row = {1'b0, r};
              mv_col = {1'b0, c - COL_W'(1)};
            end
          end
          SEQ_COLOR9:   mode_nxt = MODE_COL9;
          SEQ_COLOR0:   mode_nxt = MODE_COL0;
          SEQ_ADDR:     mode_nxt = MODE_YROW;
          SEQ_PALETTE:  mode_nxt = MODE_PALSEL;
          SEQ_TITLE:    mode_nxt = MODE_TSTART;
          SEQ_KEY_BIND: mode_nxt = MODE_KEY;
          SEQ_KEY_REP:  mode_nxt = MODE_RKEY;
          default: ;
        endcase
      end
      MODE_COL9: begin
        emit      = 1'b1;
        res.cmd   = CMD_TEXT_COLOR;
        res.value = COLOR_NINE;
      end
      MODE_COL0: begin
        emit      = 1'b1;
        res.cmd   = CMD_TEXT_COLOR;
        res.value = COLOR_ZERO;
      end
      MODE_YROW: begin
        fsb_nxt  = byte_in;
        mode_nxt = MODE_YCOL;
      end
      MODE_YCOL: begin
        if ((byte_in >= CH_SPACE) && (9'(ycol_m) <= 9'(cols_last)) &&
            (fsb_r >= CH_SPACE) && (9'(yrow_m) <= 9'(rows_last))) begin
          mv     = 1'b1;
          mv_row = (ROW_W + 1)'(yrow_m);
          mv_col = (COL_W + 1)'(ycol_m);
        end
      end
      MODE_PALSEL: begin
        fsb_nxt  = byte_in;
        mode_nxt = MODE_PALVAL;
      end
      MODE_PALVAL: begin
        res.cmd   = CMD_PALETTE;
        res.value = byte_in - CH_ZERO;
        unique case (fsb_r) inside
          SEL_FG_LO, SEL_FG_UP: begin
            emit     = 1'b1;
            res.slot = SLOT_FG;
          end
          SEL_BG_LO, SEL_BG_UP: begin
            emit     = 1'b1;
            res.slot = SLOT_BG;
          end
          SEL_REV_LO, SEL_REV_UP: begin
            emit     = 1'b1;
            res.slot = SLOT_REV;
          end
          default: ;
        endcase
      end
      MODE_TSTART: begin
        delim_nxt = byte_in;
        cnt_nxt   = '0;
        mode_nxt  = MODE_TBODY;
      end
      MODE_TBODY: begin
        emit = 1'b1;
        if (str_end) begin
          res.cmd = CMD_TITLE_END;
        end else begin
          res.cmd   = CMD_TITLE_CHAR;
          res.value = byte_in;
          cnt_nxt   = cnt_r + CNT_W'(1);
          mode_nxt  = MODE_TBODY;
        end
      end
      MODE_KEY: begin
        fsb_nxt  = byte_in;
        mode_nxt = MODE_KDELIM;
      end
      MODE_KDELIM: begin
        delim_nxt = byte_in;
        cnt_nxt   = '0;
        mode_nxt  = MODE_KBODY;
      end
      MODE_KBODY: begin
        if (!str_end) begin
          cnt_nxt  = cnt_r + CNT_W'(1);
          mode_nxt = MODE_KBODY;
        end
      end
      MODE_RKEY: begin
        fsb_nxt  = byte_in;
        mode_nxt = MODE_RDONE;
      end
      default: ;
    endcase

    if (mv) begin
      emit    = 1'b1;
      res.cmd = CMD_MOVE;
      if (mv_row > {1'b0, rows_last}) begin
        row_nxt    = rows_last;
        res.scroll = 1'b1;
      end else begin
        row_nxt = mv_row[ROW_W-1:0];
      end
      if (mv_col > {1'b0, cols_last}) begin
        col_nxt = cols_last;
      end else begin
        col_nxt = mv_col[COL_W-1:0];
      end
      res.row = 6'(row_nxt);
      res.col = 7'(col_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      row_r   <= '0;
      col_r   <= '0;
      fsb_r   <= '0;
      delim_r <= '0;
      cnt_r   <= '0;
    end else if (go) begin
      mode_r  <= mode_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      fsb_r   <= fsb_nxt;
      delim_r <= delim_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- design/terminal_escape_decoder_unit.sv -----
// Top level of the terminal escape decoder: input register, decode, result register.
//
// Takes one byte per clock while not stalled and gives at most one display command per
// byte. A byte sits in the input register, is decoded against the escape state and
// cursor in one pass, and its command lands in the result register, with a sustained
// rate of one byte per cycle set by the single-pass decode while the input is not
// stalled. The input stalls only while the byte held in the input register makes a
// command and the result register is full and stalled. Screen size writes take effect
// on the next byte; the cursor is pulled inside a shrunk screen before that byte.
module terminal_escape_decoder_unit #(
  parameter int MAX_COLS     = 128,
  parameter int MAX_ROWS     = 64,
  parameter int STRING_LIMIT = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_byte_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [3:0]                     out_command,
  output logic [5:0]                     out_cursor_row,
  output logic [6:0]                     out_cursor_col,
  output logic [7:0]                     out_value,
  output logic [1:0]                     out_palette_slot,
  output logic                           out_scroll_up,
  input  logic                           cfg_we,
  input  logic [ted_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ted_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ted_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_r;
  res_t             p_res;
  logic             p_emit;
  logic             go;
  logic [COL_W-1:0] cols_last;
  logic [ROW_W-1:0] rows_last;

  ted_cfg #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cols_last (cols_last),
    .rows_last (rows_last)
  );

  ted_parser #(
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .STRING_LIMIT(STRING_LIMIT)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .byte_in   (s1_byte_r),
    .cols_last (cols_last),
    .rows_last (rows_last),
    .emit      (p_emit),
    .res       (p_res)
  );

  assign go       = s1_valid_r && (!p_emit || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte_value;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go && p_emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && p_emit) begin
      out_r <= p_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_command      = out_r.cmd;
  assign out_cursor_row   = out_r.row;
  assign out_cursor_col   = out_r.col;
  assign out_value        = out_r.value;
  assign out_palette_slot = out_r.slot;
  assign out_scroll_up    = out_r.scroll;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (go && p_emit) |-> (!out_valid_r || !out_stall))
    else $error("result register loaded while holding a stalled result");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !(go && p_emit)) |=> !out_valid_r)
    else $error("result stays valid after its transfer");

  a_scroll_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.cmd != CMD_PUT_CHAR && out_r.cmd != CMD_MOVE)
      |-> !out_r.scroll)
    else $error("scroll flag on a command that never moves the cursor");

endmodule

// ----- verif/terminal_escape_decoder_unit_tb.sv -----
// Self-checking testbench of the terminal escape decoder: directed and random byte streams.
`timescale 1ns / 100ps

module testbench;
  import ted_pkg::*;

  localparam int MAX_COLS     = 128;
  localparam int MAX_ROWS     = 64;
  localparam int STRING_LIMIT = 64;
  localparam int PHASE_BYTES  = 108;
  localparam int SETTLE       = 6;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_LITERAL} row_kind_t;

  typedef struct packed {
    logic [7:0] data;
    row_kind_t  kind;
    res_t       res;
  } stim_row_t;

  localparam res_t NO_RES = '{CMD_PUT_CHAR, 6'd0, 7'd0, 8'd0, SLOT_FG, 1'b0};

  localparam int N_DIRECTED = 63;
  localparam stim_row_t DIRECTED [0:N_DIRECTED-1] = '{
    '{8'h41, ROW_LITERAL, '{CMD_PUT_CHAR, 6'd0, 7'd0, 8'h41, SLOT_FG, 1'b0}},
    '{CH_BEL, ROW_LITERAL, '{CMD_BELL, 6'd0, 7'd1, 8'h00, SLOT_FG, 1'b0}},
    '{CH_BS, ROW_PREDICT, NO_RES},
    '{CH_BS, ROW_NONE, NO_RES},
    '{8'hFF, ROW_PREDICT, NO_RES},
    '{CH_TAB, ROW_PREDICT, NO_RES},
    '{CH_LF, ROW_PREDICT, NO_RES},
    '{CH_CR, ROW_PREDICT, NO_RES},
    '{8'h00, ROW_NONE, NO_RES},
    '{CH_ESC, ROW_NONE, NO_RES}, '{SEQ_CLEAR_EOL, ROW_PREDICT, NO_RES},
    '{CH_ESC, ROW_NONE, NO_RES}, '{SEQ_INS_LINE, ROW_PREDICT, NO_RES},
    '{CH_ESC, ROW_NONE, NO_RES}, '{SEQ_DEL_LINE, ROW_PREDICT, NO_RES},
    '{CH_ESC, ROW_NONE, NO_RES}, '{SEQ_REV_INDEX, ROW_PREDICT, NO_RES},
    '{CH_ESC, ROW_NONE, NO_RES},
    '{SEQ_REV_INDEX, ROW_LITERAL, '{CMD_INS_LINE, 6'd0, 7'd0, 8'h00, SLOT_FG, 1'b0}},
    '{CH_ESC, ROW_NONE, NO_RES}, '{SEQ_UP, ROW_NONE, NO_RES},
    '{CH_ESC, ROW_NONE, NO_RES}, '{SEQ_DOWN, ROW_PREDICT, NO_RES},
    '{CH_ESC, ROW_NONE, NO_RES}, '{SEQ_RIGHT, ROW_PREDICT, NO_RES},
    '{CH_ESC, ROW_NONE, NO_RES}, '{SEQ_LEFT, ROW_PREDICT, NO_RES},
    '{CH_ESC, ROW_NONE, NO_RES}, '{SEQ_COLOR9, ROW_NONE, NO_RES},
    '{8'h55, ROW_LITERAL, '{CMD_TEXT_COLOR, 6'd1, 7'd0, COLOR_NINE, SLOT_FG, 1'b0}},
    '{CH_ESC, ROW_NONE, NO_RES}, '{SEQ_COLOR0, ROW_NONE, NO_RES},
    '{8'hAA, ROW_LITERAL, '{CMD_TEXT_COLOR, 6'd1, 7'd0, COLOR_ZERO, SLOT_FG, 1'b0}},
    '{CH_ESC, ROW_NONE, NO_RES}, '{SEQ_ADDR, ROW_NONE, NO_RES},
    '{8'h47, ROW_NONE, NO_RES}, '{8'h6F, ROW_PREDICT, NO_RES},
    '{8'h7E, ROW_LITERAL, '{CMD_PUT_CHAR, 6'd39, 7'd79, 8'h7E, SLOT_FG, 1'b1}},
    '{CH_ESC, ROW_NONE, NO_RES}, '{SEQ_ADDR, ROW_NONE, NO_RES},
    '{8'hFF, ROW_NONE, NO_RES}, '{8'h20, ROW_NONE, NO_RES},
    '{CH_ESC, ROW_NONE, NO_RES}, '{SEQ_PALETTE, ROW_NONE, NO_RES},
    '{SEL_REV_UP, ROW_NONE, NO_RES},
    '{8'h00, ROW_LITERAL, '{CMD_PALETTE, 6'd39, 7'd0, 8'hD0, SLOT_REV, 1'b0}},
    '{CH_ESC, ROW_NONE, NO_RES}, '{SEQ_PALETTE, ROW_NONE, NO_RES},
    '{8'h63, ROW_NONE, NO_RES}, '{8'h35, ROW_NONE, NO_RES},
    '{CH_ESC, ROW_NONE, NO_RES}, '{SEQ_TITLE, ROW_NONE, NO_RES},
    '{8'h2F, ROW_NONE, NO_RES}, '{8'h61, ROW_PREDICT, NO_RES}, '{8'h2F, ROW_PREDICT, NO_RES},
    '{CH_ESC, ROW_NONE, NO_RES}, '{SEQ_KEY_BIND, ROW_NONE, NO_RES},
    '{8'h41, ROW_NONE, NO_RES}, '{8'h2C, ROW_NONE, NO_RES},
    '{8'h61, ROW_NONE, NO_RES}, '{8'h2C, ROW_NONE, NO_RES},
    '{CH_ESC, ROW_NONE, NO_RES},
    '{SEQ_HOME_CLR, ROW_LITERAL, '{CMD_CLEAR_EOS, 6'd0, 7'd0, 8'h00, SLOT_FG, 1'b0}}
  };

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_byte_value  = 8'd0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [3:0]            out_command;
  logic [5:0]            out_cursor_row;
  logic [6:0]            out_cursor_col;
  logic [7:0]            out_value;
  logic [1:0]            out_palette_slot;
  logic                  out_scroll_up;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  terminal_escape_decoder_unit dut (.*);

  always #2 clk = ~clk;

  // predictor state
  logic [7:0] scr_cols_reg;
  logic [6:0] scr_rows_reg;
  mode_t      pmode;
  logic [5:0] cur_row;
  logic [6:0] cur_col;
  logic [7:0] saved_byte;
  logic [7:0] delim_byte;
  logic [6:0] str_count;

  stim_row_t stim_info [$];
  res_t      expected_cmds [$];
  int        fail_count  = 0;
  int        phase_bytes = 0;
  bit        quiet       = 1'b0;

  function automatic int eff_cols();
    if (scr_cols_reg == 0) return 1;
    if (scr_cols_reg > MAX_COLS) return MAX_COLS;
    return scr_cols_reg;
  endfunction

  function automatic int eff_rows();
    if (scr_rows_reg == 0) return 1;
    if (scr_rows_reg > MAX_ROWS) return MAX_ROWS;
    return scr_rows_reg;
  endfunction

  function automatic res_t grid_cmd(cmd_t cmd, int r, int c, logic [7:0] v, logic [1:0] s,
                                    logic sc);
    res_t res;
    res.cmd    = cmd;
    res.row    = 6'(r);
    res.col    = 7'(c);
    res.value  = v;
    res.slot   = s;
    res.scroll = sc;
    return res;
  endfunction

  function automatic res_t move_cursor(int r, int c);
    int   rows;
    int   cols;
    logic scr;
    rows = eff_rows();
    cols = eff_cols();
    scr  = 1'b0;
    if (r >= rows) begin
      r   = rows - 1;
      scr = 1'b1;
    end
    if (c >= cols) c = cols - 1;
    cur_row = 6'(r);
    cur_col = 7'(c);
    return grid_cmd(CMD_MOVE, r, c, 8'd0, SLOT_FG, scr);
  endfunction

  function automatic void decode_byte(input logic [7:0] b, output bit made, output res_t res);
    int         rows;
    int         cols;
    int         r;
    int         c;
    int         nxt;
    mode_t      m;
    logic [1:0] slot;
    logic       scr;
    rows = eff_rows();
    cols = eff_cols();
    if (cur_row >= rows) cur_row = 6'(rows - 1);
    if (cur_col >= cols) cur_col = 7'(cols - 1);
    r     = cur_row;
    c     = cur_col;
    m     = pmode;
    pmode = MODE_NORMAL;
    made  = 1'b1;
    slot  = SLOT_FG;
    res   = NO_RES;
    case (m)
      MODE_NORMAL: begin
        if (b >= CH_SPACE) begin
          scr = 1'b0;
          if (c + 1 >= cols) begin
            cur_col = 7'd0;
            if (r + 1 >= rows) scr = 1'b1;
            else cur_row = 6'(r + 1);
          end else begin
            cur_col = 7'(c + 1);
          end
          res = grid_cmd(CMD_PUT_CHAR, r, c, b, SLOT_FG, scr);
        end else begin
          case (b)
            CH_ESC: begin
              pmode = MODE_ESC;
              made  = 1'b0;
            end
            CH_BS: begin
              if (c != 0) res = move_cursor(r, c - 1);
              else made = 1'b0;
            end
            CH_BEL: res = grid_cmd(CMD_BELL, r, c, 8'd0, SLOT_FG, 1'b0);
            CH_LF: res = move_cursor(r + 1, c);
            CH_CR: res = move_cursor(r, 0);
            CH_TAB: begin
              nxt = c + 8 - (c & 7);
              if (nxt >= cols) res = move_cursor(r + 1, 0);
              else res = move_cursor(r, nxt);
            end
            default: made = 1'b0;
          endcase
        end
      end
      MODE_ESC: begin
        case (b)
          SEQ_CLEAR_EOS: res = grid_cmd(CMD_CLEAR_EOS, r, c, 8'd0, SLOT_FG, 1'b0);
          SEQ_CLEAR_EOL: res = grid_cmd(CMD_CLEAR_EOL, r, c, 8'd0, SLOT_FG, 1'b0);
          SEQ_HOME_CLR: begin
            cur_row = 6'd0;
            cur_col = 7'd0;
            res     = grid_cmd(CMD_CLEAR_EOS, 0, 0, 8'd0, SLOT_FG, 1'b0);
          end
          SEQ_INS_LINE: res = grid_cmd(CMD_INS_LINE, r, c, 8'd0, SLOT_FG, 1'b0);
          SEQ_DEL_LINE: res = grid_cmd(CMD_DEL_LINE, r, c, 8'd0, SLOT_FG, 1'b0);
          SEQ_HOME: res = move_cursor(0, 0);
          SEQ_REV_INDEX: begin
            if (r == 0) res = grid_cmd(CMD_INS_LINE, r, c, 8'd0, SLOT_FG, 1'b0);
            else res = move_cursor(r - 1, c);
          end
          SEQ_UP: begin
            if (r != 0) res = move_cursor(r - 1, c);
            else made = 1'b0;
          end
          SEQ_DOWN: begin
            if (r + 1 < rows) res = move_cursor(r + 1, c);
            else made = 1'b0;
          end
          SEQ_RIGHT: begin
            if (c + 1 < cols) res = move_cursor(r, c + 1);
            else made = 1'b0;
          end
          SEQ_LEFT: begin
            if (c != 0) res = move_cursor(r, c - 1);
            else made = 1'b0;
          end
          SEQ_COLOR9: begin
            pmode = MODE_COL9;
            made  = 1'b0;
          end
          SEQ_COLOR0: begin
            pmode = MODE_COL0;
            made  = 1'b0;
          end
          SEQ_ADDR: begin
            pmode = MODE_YROW;
            made  = 1'b0;
          end
          SEQ_PALETTE: begin
            pmode = MODE_PALSEL;
            made  = 1'b0;
          end
          SEQ_TITLE: begin
            pmode = MODE_TSTART;
            made  = 1'b0;
          end
          SEQ_KEY_BIND: begin
            pmode = MODE_KEY;
            made  = 1'b0;
          end
          SEQ_KEY_REP: begin
            pmode = MODE_RKEY;
            made  = 1'b0;
          end
          default: made = 1'b0;
        endcase
      end
      MODE_COL9: res = grid_cmd(CMD_TEXT_COLOR, r, c, COLOR_NINE, SLOT_FG, 1'b0);
      MODE_COL0: res = grid_cmd(CMD_TEXT_COLOR, r, c, COLOR_ZERO, SLOT_FG, 1'b0);
      MODE_YROW: begin
        saved_byte = b;
        pmode      = MODE_YCOL;
        made       = 1'b0;
      end
      MODE_YCOL: begin
        if (b < CH_SPACE || b >= 32 + cols || saved_byte < CH_SPACE || saved_byte >= 32 + rows)
          made = 1'b0;
        else
          res = move_cursor(int'(saved_byte) - 32, int'(b) - 32);
      end
      MODE_PALSEL: begin
        saved_byte = b;
        pmode      = MODE_PALVAL;
        made       = 1'b0;
      end
      MODE_PALVAL: begin
        case (saved_byte)
          SEL_FG_LO, SEL_FG_UP: slot = SLOT_FG;
          SEL_BG_LO, SEL_BG_UP: slot = SLOT_BG;
          SEL_REV_LO, SEL_REV_UP: slot = SLOT_REV;
          default: made = 1'b0;
        endcase
        if (made) res = grid_cmd(CMD_PALETTE, r, c, b - CH_ZERO, slot, 1'b0);
      end
      MODE_TSTART: begin
        delim_byte = b;
        str_count  = 7'd0;
        pmode      = MODE_TBODY;
        made       = 1'b0;
      end
      MODE_TBODY: begin
        if (b == delim_byte || b == CH_LF || str_count >= STRING_LIMIT) begin
          res = grid_cmd(CMD_TITLE_END, r, c, 8'd0, SLOT_FG, 1'b0);
        end else begin
          str_count = str_count + 7'd1;
          pmode     = MODE_TBODY;
          res       = grid_cmd(CMD_TITLE_CHAR, r, c, b, SLOT_FG, 1'b0);
        end
      end
      MODE_KEY: begin
        saved_byte = b;
        pmode      = MODE_KDELIM;
        made       = 1'b0;
      end
      MODE_KDELIM: begin
        delim_byte = b;
        str_count  = 7'd0;
        pmode      = MODE_KBODY;
        made       = 1'b0;
      end
      MODE_KBODY: begin
        if (!(b == delim_byte || b == CH_LF || str_count >= STRING_LIMIT)) begin
          str_count = str_count + 7'd1;
          pmode     = MODE_KBODY;
        end
        made = 1'b0;
      end
      MODE_RKEY: begin
        saved_byte = b;
        pmode      = MODE_RDONE;
        made       = 1'b0;
      end
      default: made = 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin : scoreboard
    stim_row_t rec;
    res_t      want;
    bit        made;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected transfer, command %0d row %0d col %0d", $time,
                 out_command, out_cursor_row, out_cursor_col);
        fail_count++;
      end else begin
        want = expected_cmds.pop_front();
        if (out_command !== want.cmd) begin
          $display("%0t: command expected %0d actual %0d", $time, want.cmd, out_command);
          fail_count++;
        end
        if (out_cursor_row !== want.row) begin
          $display("%0t: cursor_row expected %0d actual %0d", $time, want.row, out_cursor_row);
          fail_count++;
        end
        if (out_cursor_col !== want.col) begin
          $display("%0t: cursor_col expected %0d actual %0d", $time, want.col, out_cursor_col);
          fail_count++;
        end
        if (out_value !== want.value) begin
          $display("%0t: value expected %0h actual %0h", $time, want.value, out_value);
          fail_count++;
        end
        if (out_palette_slot !== want.slot) begin
          $display("%0t: palette_slot expected %0d actual %0d", $time, want.slot,
                   out_palette_slot);
          fail_count++;
        end
        if (out_scroll_up !== want.scroll) begin
          $display("%0t: scroll_up expected %0d actual %0d", $time, want.scroll, out_scroll_up);
          fail_count++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      rec = stim_info.pop_front();
      decode_byte(in_byte_value, made, want);
      if (rec.kind == ROW_NONE) made = 1'b0;
      if (rec.kind == ROW_LITERAL) begin
        made = 1'b1;
        want = rec.res;
      end
      if (made) expected_cmds.push_back(want);
    end
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 7);
  end

  task automatic send_byte(input logic [7:0] b, input row_kind_t k, input res_t r);
    stim_row_t rec;
    if (!quiet && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    rec = '{b, k, r};
    stim_info.push_back(rec);
    in_valid      <= 1'b1;
    in_byte_value <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    phase_bytes++;
  endtask

  task automatic stream_byte(input logic [7:0] b);
    send_byte(b, ROW_PREDICT, NO_RES);
  endtask

  // hold the input, let every expected result drain, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_screen(input logic [7:0] cols, input logic [7:0] rows);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COLUMNS;
    cfg_data  <= cols;
    @(posedge clk);
    scr_cols_reg = cols;
    cfg_index <= CFG_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    scr_rows_reg = rows[6:0];
    cfg_we <= 1'b0;
  endtask

  task automatic send_delimited(input logic [7:0] d);
    int         n;
    logic [7:0] ch;
    n = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
    stream_byte(d);
    repeat (n) begin
      do ch = 8'($urandom); while (ch == d || ch == CH_LF);
      stream_byte(ch);
    end
    case ($urandom_range(3))
      0: stream_byte(CH_LF);
      1, 2: stream_byte(d);
      default: ;
    endcase
  endtask

  task automatic emit_sequence();
    int pick;
    pick = $urandom_range(99);
    if (pick < 22) begin
      repeat ($urandom_range(1, 6)) stream_byte(8'($urandom_range(32, 255)));
    end else if (pick < 34) begin
      case ($urandom_range(6))
        0: stream_byte(CH_BEL);
        1: stream_byte(CH_BS);
        2: stream_byte(CH_TAB);
        3: stream_byte(CH_LF);
        4: stream_byte(CH_CR);
        default: stream_byte(8'($urandom_range(0, 31)));
      endcase
    end else if (pick < 52) begin
      stream_byte(CH_ESC);
      case ($urandom_range(10))
        0: stream_byte(SEQ_CLEAR_EOS);
        1: stream_byte(SEQ_CLEAR_EOL);
        2: stream_byte(SEQ_HOME_CLR);
        3: stream_byte(SEQ_INS_LINE);
        4: stream_byte(SEQ_DEL_LINE);
        5: stream_byte(SEQ_HOME);
        6: stream_byte(SEQ_REV_INDEX);
        7: stream_byte(SEQ_UP);
        8: stream_byte(SEQ_DOWN);
        9: stream_byte(SEQ_RIGHT);
        default: stream_byte(SEQ_LEFT);
      endcase
    end else if (pick < 58) begin
      stream_byte(CH_ESC);
      stream_byte($urandom_range(1) ? SEQ_COLOR9 : SEQ_COLOR0);
      stream_byte(8'($urandom));
    end else if (pick < 68) begin
      stream_byte(CH_ESC);
      stream_byte(SEQ_ADDR);
      if ($urandom_range(9) < 8) begin
        stream_byte(8'(32 + $urandom_range(eff_rows() - 1)));
        stream_byte(8'(32 + $urandom_range(eff_cols() - 1)));
      end else begin
        stream_byte(8'($urandom));
        stream_byte(8'($urandom));
      end
    end else if (pick < 76) begin
      stream_byte(CH_ESC);
      stream_byte(SEQ_PALETTE);
      case ($urandom_range(8))
        0: stream_byte(SEL_FG_LO);
        1: stream_byte(SEL_FG_UP);
        2: stream_byte(SEL_BG_LO);
        3: stream_byte(SEL_BG_UP);
        4: stream_byte(SEL_REV_LO);
        5: stream_byte(SEL_REV_UP);
        6: stream_byte(8'h63);
        7: stream_byte(8'h43);
        default: stream_byte(8'($urandom));
      endcase
      stream_byte(8'($urandom));
    end else if (pick < 86) begin
      stream_byte(CH_ESC);
      stream_byte(SEQ_TITLE);
      send_delimited(8'($urandom));
    end else if (pick < 91) begin
      stream_byte(CH_ESC);
      stream_byte(SEQ_KEY_BIND);
      stream_byte(8'($urandom));
      send_delimited(8'($urandom));
    end else if (pick < 94) begin
      stream_byte(CH_ESC);
      stream_byte(SEQ_KEY_REP);
      stream_byte(8'($urandom));
      stream_byte(8'($urandom));
    end else if (pick < 97) begin
      stream_byte(CH_ESC);
      stream_byte(8'($urandom));
    end else begin
      stream_byte(8'($urandom));
    end
  endtask

  initial begin
    logic [7:0] cols;
    logic [7:0] rows;
    scr_cols_reg = 8'd80;
    scr_rows_reg = 7'd40;
    pmode        = MODE_NORMAL;
    cur_row      = 6'd0;
    cur_col      = 7'd0;
    saved_byte   = 8'd0;
    delim_byte   = 8'd0;
    str_count    = 7'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIRECTED; i++)
      send_byte(DIRECTED[i].data, DIRECTED[i].kind, DIRECTED[i].res);
    wait_idle();
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin cols = 8'd80;  rows = 8'd40;  end
        1: begin cols = 8'd128; rows = 8'd64;  end
        2: begin cols = 8'd1;   rows = 8'd1;   end
        3: begin cols = 8'd0;   rows = 8'd0;   end
        4: begin cols = 8'd255; rows = 8'd255; end
        5: begin cols = 8'd8;   rows = 8'd3;   end
        6: begin cols = 8'($urandom); rows = 8'($urandom); end
        7: begin cols = 8'($urandom_range(1, 16)); rows = 8'($urandom_range(1, 8)); end
        default: begin cols = 8'd80; rows = 8'd40; end
      endcase
      set_screen(cols, rows);
      quiet       = (phase == 1);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) emit_sequence();
      wait_idle();
    end
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
